// ===== rtl/gqg_pkg.sv =====
package gqg_pkg;

    // Request kinds carried in req_type.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_CHAR = 1'b1;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_UNIT_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_UNIT_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GLYPH_WIDTH = 3'd5;
    localparam int CFG_DATA_W = 16;

    // Atlas layout: the low nibble of a code picks the column, the high nibble the row.
    localparam int ATLAS_COLUMNS = 16;
    localparam int COL_W         = $clog2(ATLAS_COLUMNS);
    localparam int ROW_W         = 8 - COL_W;

    localparam int TEX_W = 17;
    localparam logic [TEX_W-1:0] TEX_MAX = 17'h1FFFF;

    // Texture step divider: numerator is width times column size.
    localparam int DIV_NUM_W = 24;
    localparam int DIV_DEN_W = 8;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam int VTX_IDX_W = 3;
    localparam logic [VTX_IDX_W-1:0] LAST_VTX_IDX = 3'd5;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_code;
        logic [7:0] glyph_width;
        logic [7:0] glyph_advance;
        logic       first_char;
    } gqg_req_t;

    typedef struct packed {
        logic [15:0]      pos_x;
        logic [15:0]      pos_y;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        logic             last_vertex;
    } gqg_vtx_t;

    typedef struct packed {
        logic [7:0] width;
        logic [7:0] advance;
    } gqg_glyph_t;

endpackage

// ===== rtl/gqg_glyph_ram.sv =====
module gqg_glyph_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  gqg_pkg::gqg_glyph_t wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output gqg_pkg::gqg_glyph_t rdata
);
    import gqg_pkg::*;

    gqg_glyph_t mem [DEPTH];
    gqg_glyph_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gqg_divider.sv =====
module gqg_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [gqg_pkg::DIV_NUM_W-1:0]  numer,
    input  logic [gqg_pkg::DIV_DEN_W-1:0]  denom,
    output logic                           done,
    output logic [gqg_pkg::DIV_NUM_W-1:0]  quotient
);
    import gqg_pkg::*;

    // Restoring division, one quotient bit per cycle, MSB first.
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   work;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    always_comb
    begin
        work = {rem_reg, quo_reg[DIV_NUM_W-1]};
        diff = work - {1'b0, den_reg};
        ge   = (work >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIV_CNT_W'(DIV_NUM_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DIV_DEN_W-1:0] : work[DIV_DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/glyph_quad_generator_top.sv =====
// Glyph quad generator: a load beat writes the width and advance of one glyph into the
// table; a newline character moves the pen and emits nothing. Any other character goes
// through these steps in order: the accept, a table read, the multiplies, a divider
// start, the bit-serial divider for the texture step (24 quotient bits and a done flag,
// dividing width times column size by max_glyph_width), a saturation step and six vertex
// emits. The receiver holding off one of the first five vertices stalls the emits.
// The sixth vertex may wait in the output register while the next request is already
// being worked on.
module glyph_quad_generator_top #(
    parameter int GLYPH_COUNT = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  gqg_pkg::gqg_req_t                    req_data,
    output logic                                 vtx_valid,
    input  logic                                 vtx_ready,
    output gqg_pkg::gqg_vtx_t                    vtx_data,
    input  logic                                 cfg_we,
    input  logic [gqg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gqg_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import gqg_pkg::*;

    localparam int AW = $clog2(GLYPH_COUNT);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_SAT,
        ST_EMIT
    } state_t;

    state_t state_reg;

    logic [15:0] origin_x_reg;
    logic [15:0] origin_y_reg;
    logic [7:0]  line_height_reg;
    logic [15:0] tex_unit_x_reg;
    logic [15:0] tex_unit_y_reg;
    logic [7:0]  max_glyph_width_reg;

    logic [15:0] pen_x_reg;
    logic [15:0] pen_y_reg;

    logic [7:0]           code_reg;
    logic                 in_range_reg;
    logic [7:0]           w_reg;
    logic [7:0]           adv_reg;
    logic [DIV_NUM_W-1:0] prod_reg;
    logic [19:0]          u0raw_reg;
    logic [19:0]          v0raw_reg;
    logic [15:0]          x0_reg;
    logic [15:0]          y0_reg;
    logic [15:0]          x1_reg;
    logic [15:0]          y1_reg;
    logic [TEX_W-1:0]     u0_reg;
    logic [TEX_W-1:0]     u1_reg;
    logic [TEX_W-1:0]     v0_reg;
    logic [TEX_W-1:0]     v1_reg;
    logic [VTX_IDX_W-1:0] vtx_idx_reg;

    logic      vtx_valid_reg;
    gqg_vtx_t  vtx_data_reg;
    gqg_vtx_t  vtx_next;

    logic                 req_accept;
    logic                 req_in_range;
    logic [15:0]          base_x;
    logic [15:0]          base_y;
    logic                 ram_we;
    gqg_glyph_t           ram_wdata;
    gqg_glyph_t           ram_rdata;
    logic                 div_start;
    logic                 div_done;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quo;
    logic [24:0]          u1_sum;
    logic [20:0]          v1_sum;
    logic                 slot_free;

    assign req_ready    = (state_reg == ST_IDLE);
    assign req_accept   = req_valid && req_ready;
    assign req_in_range = ({1'b0, req_data.char_code} < 9'(GLYPH_COUNT));
    assign base_x       = req_data.first_char ? origin_x_reg : pen_x_reg;
    assign base_y       = req_data.first_char ? origin_y_reg : pen_y_reg;

    assign ram_we    = req_accept && (req_data.req_type == REQ_LOAD) && req_in_range;
    assign ram_wdata = {req_data.glyph_width, req_data.glyph_advance};

    gqg_glyph_ram #(
        .DEPTH (GLYPH_COUNT),
        .AW    (AW)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (req_data.char_code[AW-1:0]),
        .wdata (ram_wdata),
        .re    (req_accept),
        .raddr (req_data.char_code[AW-1:0]),
        .rdata (ram_rdata)
    );

    // A zero divisor is taken as one.
    assign div_den   = (max_glyph_width_reg == '0) ? DIV_DEN_W'(1) : max_glyph_width_reg;
    assign div_start = (state_reg == ST_START);

    gqg_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (prod_reg),
        .denom    (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign u1_sum    = {5'b0, u0raw_reg} + {1'b0, div_quo};
    assign v1_sum    = {1'b0, v0raw_reg} + {5'b0, tex_unit_y_reg};
    assign slot_free = !vtx_valid_reg || vtx_ready;

    // Vertex order: two triangles sharing the diagonal from the top-left to bottom-right.
    always_comb
    begin
        vtx_next = '0;
        unique case (vtx_idx_reg)
            3'd0, 3'd3:
            begin
                vtx_next.pos_x = x0_reg;
                vtx_next.pos_y = y0_reg;
                vtx_next.tex_u = u0_reg;
                vtx_next.tex_v = v0_reg;
            end
            3'd1, 3'd5:
            begin
                vtx_next.pos_x = x1_reg;
                vtx_next.pos_y = y1_reg;
                vtx_next.tex_u = u1_reg;
                vtx_next.tex_v = v1_reg;
            end
            3'd2:
            begin
                vtx_next.pos_x = x0_reg;
                vtx_next.pos_y = y1_reg;
                vtx_next.tex_u = u0_reg;
                vtx_next.tex_v = v1_reg;
            end
            3'd4:
            begin
                vtx_next.pos_x = x1_reg;
                vtx_next.pos_y = y0_reg;
                vtx_next.tex_u = u1_reg;
                vtx_next.tex_v = v0_reg;
            end
            default:
            begin
                vtx_next = '0;
            end
        endcase
        vtx_next.last_vertex = (vtx_idx_reg == LAST_VTX_IDX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg        <= 16'd0;
            origin_y_reg        <= 16'd0;
            line_height_reg     <= 8'd16;
            tex_unit_x_reg      <= 16'd4096;
            tex_unit_y_reg      <= 16'd8192;
            max_glyph_width_reg <= 8'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X:        origin_x_reg        <= cfg_data;
                CFG_ORIGIN_Y:        origin_y_reg        <= cfg_data;
                CFG_LINE_HEIGHT:     line_height_reg     <= cfg_data[7:0];
                CFG_TEX_UNIT_X:      tex_unit_x_reg      <= cfg_data;
                CFG_TEX_UNIT_Y:      tex_unit_y_reg      <= cfg_data;
                CFG_MAX_GLYPH_WIDTH: max_glyph_width_reg <= cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pen_x_reg     <= 16'd0;
            pen_y_reg     <= 16'd0;
            vtx_idx_reg   <= '0;
            vtx_valid_reg <= 1'b0;
        end
        else
        begin
            if (vtx_valid_reg && vtx_ready && !((state_reg == ST_EMIT) && slot_free))
            begin
                vtx_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_accept && (req_data.req_type == REQ_CHAR))
                    begin
                        if (req_data.char_code == NEWLINE_CODE)
                        begin
                            pen_x_reg <= origin_x_reg;
                            pen_y_reg <= base_y + {8'd0, line_height_reg};
                        end
                        else
                        begin
                            pen_x_reg <= base_x;
                            pen_y_reg <= base_y;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_START;
                end
                ST_START:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT:
                begin
                    pen_x_reg   <= pen_x_reg + {8'd0, adv_reg};
                    vtx_idx_reg <= '0;
                    state_reg   <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        vtx_valid_reg <= 1'b1;
                        vtx_idx_reg   <= vtx_idx_reg + 1'b1;
                        if (vtx_idx_reg == LAST_VTX_IDX)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            code_reg     <= req_data.char_code;
            in_range_reg <= req_in_range;
        end
        if (state_reg == ST_READ)
        begin
            w_reg   <= in_range_reg ? ram_rdata.width : 8'd0;
            adv_reg <= in_range_reg ? ram_rdata.advance : 8'd0;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg  <= DIV_NUM_W'(w_reg) * DIV_NUM_W'(tex_unit_x_reg);
            u0raw_reg <= 20'(tex_unit_x_reg) * 20'(code_reg[COL_W-1:0]);
            v0raw_reg <= 20'(tex_unit_y_reg) * 20'(code_reg[7:COL_W]);
        end
        if (state_reg == ST_SAT)
        begin
            x0_reg <= pen_x_reg;
            y0_reg <= pen_y_reg;
            x1_reg <= pen_x_reg + {8'd0, w_reg};
            y1_reg <= pen_y_reg + {8'd0, line_height_reg};
            u0_reg <= (u0raw_reg > 20'(TEX_MAX)) ? TEX_MAX : u0raw_reg[TEX_W-1:0];
            u1_reg <= (u1_sum > 25'(TEX_MAX)) ? TEX_MAX : u1_sum[TEX_W-1:0];
            v0_reg <= (v0raw_reg > 20'(TEX_MAX)) ? TEX_MAX : v0raw_reg[TEX_W-1:0];
            v1_reg <= (v1_sum > 21'(TEX_MAX)) ? TEX_MAX : v1_sum[TEX_W-1:0];
        end
        if ((state_reg == ST_EMIT) && slot_free)
        begin
            vtx_data_reg <= vtx_next;
        end
    end

    assign vtx_valid = vtx_valid_reg;
    assign vtx_data  = vtx_data_reg;

endmodule

// ===== bench/tb.sv =====
module tb;

    import gqg_pkg::*;

    localparam int GLYPHS            = 256;
    localparam int DRAIN_CYCLES      = 48;
    localparam int LONG_HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS       = 40;

    typedef struct packed {
        gqg_req_t req;
        logic     typed;
        gqg_vtx_t first_vtx;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    gqg_req_t req_data;
    logic     vtx_valid;
    logic     vtx_ready;
    gqg_vtx_t vtx_data;
    logic     cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Register shadow and layout state kept by the bench.
    logic [15:0] reg_origin_x;
    logic [15:0] reg_origin_y;
    logic [7:0]  reg_line_height;
    logic [15:0] reg_tex_unit_x;
    logic [15:0] reg_tex_unit_y;
    logic [7:0]  reg_max_glyph_width;
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    logic [7:0]  width_of [GLYPHS];
    logic [7:0]  advance_of [GLYPHS];
    bit          glyph_loaded [GLYPHS];
    logic [7:0]  glyph_codes [$];

    gqg_vtx_t pending_vertices [$];
    dir_row_t directed_rows [$];

    bit rx_idle_on;
    bit tx_idle_on;
    bit hold_vertices;

    int mismatches;
    int vertices_checked;
    int n_loads;
    int n_chars;
    int n_newlines;
    int n_settings;

    glyph_quad_generator_top #(
        .GLYPH_COUNT(GLYPHS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx_data  (vtx_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("%0t: timeout with %0d vertices outstanding", $time, pending_vertices.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [16:0] clamp_tex(input logic [31:0] raw);
        return (raw > {15'b0, TEX_MAX}) ? TEX_MAX : raw[16:0];
    endfunction

    // Applies one accepted request to the layout state and queues the vertices it produces.
    task automatic lay_out_request(input gqg_req_t r, input logic use_typed,
                                   input gqg_vtx_t typed_vtx);
        logic [7:0]  w;
        logic [7:0]  adv;
        logic [7:0]  div;
        logic [31:0] column;
        logic [31:0] row;
        logic [31:0] step;
        logic [31:0] u0_raw;
        logic [31:0] v0_raw;
        logic [16:0] u0;
        logic [16:0] u1;
        logic [16:0] v0;
        logic [16:0] v1;
        logic [15:0] x0;
        logic [15:0] y0;
        logic [15:0] x1;
        logic [15:0] y1;
        bit          in_range;

        in_range = r.char_code < GLYPHS;
        if (r.req_type == REQ_LOAD)
        begin
            n_loads++;
            if (in_range)
            begin
                width_of[r.char_code]   = r.glyph_width;
                advance_of[r.char_code] = r.glyph_advance;
                if (!glyph_loaded[r.char_code])
                begin
                    glyph_loaded[r.char_code] = 1'b1;
                    glyph_codes.push_back(r.char_code);
                end
            end
            return;
        end

        if (r.first_char)
        begin
            pen_x = reg_origin_x;
            pen_y = reg_origin_y;
        end

        if (r.char_code == NEWLINE_CODE)
        begin
            n_newlines++;
            pen_x = reg_origin_x;
            pen_y = pen_y + reg_line_height;
            return;
        end

        n_chars++;
        w      = in_range ? width_of[r.char_code] : 8'd0;
        adv    = in_range ? advance_of[r.char_code] : 8'd0;
        div    = (reg_max_glyph_width == 8'd0) ? 8'd1 : reg_max_glyph_width;
        column = r.char_code % ATLAS_COLUMNS;
        row    = r.char_code / ATLAS_COLUMNS;
        step   = (w * reg_tex_unit_x) / div;
        u0_raw = reg_tex_unit_x * column;
        v0_raw = reg_tex_unit_y * row;
        u0     = clamp_tex(u0_raw);
        u1     = clamp_tex(u0_raw + step);
        v0     = clamp_tex(v0_raw);
        v1     = clamp_tex(v0_raw + reg_tex_unit_y);
        x0     = pen_x;
        y0     = pen_y;
        x1     = x0 + w;
        y1     = y0 + reg_line_height;

        if (use_typed)
            pending_vertices.push_back(typed_vtx);
        else
            pending_vertices.push_back({x0, y0, u0, v0, 1'b0});
        pending_vertices.push_back({x1, y1, u1, v1, 1'b0});
        pending_vertices.push_back({x0, y1, u0, v1, 1'b0});
        pending_vertices.push_back({x0, y0, u0, v0, 1'b0});
        pending_vertices.push_back({x1, y0, u1, v0, 1'b0});
        pending_vertices.push_back({x1, y1, u1, v1, 1'b1});

        pen_x = x0 + adv;
    endtask

    // Called at a falling edge; returns at a falling edge after the beat was taken, leaving valid
    // high so that a following request keeps it up without a glitch, or low after a random idle.
    task automatic drive_request(input gqg_req_t r, input logic use_typed,
                                 input gqg_vtx_t typed_vtx);
        req_data  <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        lay_out_request(r, use_typed, typed_vtx);
        @(negedge clk);
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    task automatic dir_row(input logic kind, input logic [7:0] code, input logic [7:0] w,
                           input logic [7:0] adv, input logic first, input logic typed,
                           input logic [15:0] x, input logic [15:0] y,
                           input logic [16:0] u, input logic [16:0] v);
        dir_row_t row;

        row.req       = {kind, code, w, adv, first};
        row.typed     = typed;
        row.first_vtx = {x, y, u, v, 1'b0};
        directed_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_ORIGIN_X:        reg_origin_x        = value;
            CFG_ORIGIN_Y:        reg_origin_y        = value;
            CFG_LINE_HEIGHT:     reg_line_height     = value[7:0];
            CFG_TEX_UNIT_X:      reg_tex_unit_x      = value;
            CFG_TEX_UNIT_Y:      reg_tex_unit_y      = value;
            CFG_MAX_GLYPH_WIDTH: reg_max_glyph_width = value[7:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // The byte-wide registers get junk in the upper data byte, which must be dropped.
    task automatic apply_setting(input logic [15:0] ox, input logic [15:0] oy,
                                 input logic [7:0] lh, input logic [15:0] tux,
                                 input logic [15:0] tuy, input logic [7:0] mgw);
        logic [7:0] junk;

        junk = 8'($urandom_range(0, 255));
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_LINE_HEIGHT, {junk, lh});
        write_reg(CFG_TEX_UNIT_X, tux);
        write_reg(CFG_TEX_UNIT_Y, tuy);
        write_reg(CFG_MAX_GLYPH_WIDTH, {~junk, mgw});
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Mostly text built from glyphs already loaded, with table reloads and line breaks.
    function automatic gqg_req_t random_request();
        gqg_req_t r;
        int       pick;

        r.glyph_width   = 8'($urandom_range(0, 255));
        r.glyph_advance = 8'($urandom_range(0, 255));
        r.first_char    = ($urandom_range(0, 4) == 0);
        pick            = $urandom_range(0, 99);
        if (pick < 20)
        begin
            r.req_type  = REQ_LOAD;
            r.char_code = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
                0: r.glyph_width = 8'd0;
                1: r.glyph_width = 8'd255;
                2: r.glyph_advance = 8'd255;
                default: ;
            endcase
        end
        else if (pick < 30)
        begin
            r.req_type  = REQ_CHAR;
            r.char_code = NEWLINE_CODE;
        end
        else
        begin
            r.req_type  = REQ_CHAR;
            r.char_code = glyph_codes[$urandom_range(0, glyph_codes.size() - 1)];
        end
        return r;
    endfunction

    // Called at a falling edge with valid possibly high; leaves the block idle.
    task automatic run_random(input int count, input bit rx_idle, input bit tx_idle,
                              input bit long_hold, input bit mid_pause);
        rx_idle_on = rx_idle;
        tx_idle_on = tx_idle;
        if (long_hold)
            hold_vertices = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            if (mid_pause && i == count / 2)
            begin
                req_valid <= 1'b0;
                do
                    @(negedge clk);
                while (pending_vertices.size() != 0);
            end
            drive_request(random_request(), 1'b0, '0);
        end
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_vertices.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [16:0] want,
                               input logic [16:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: vertex %0d %s expected %h actual %h",
                         $time, vertices_checked, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        gqg_vtx_t want;

        if (rst_n && vtx_valid && vtx_ready)
        begin
            if (pending_vertices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected vertex, expected none actual %h",
                             $time, vtx_data);
            end
            else
            begin
                want = pending_vertices.pop_front();
                check_field("pos_x", 17'(want.pos_x), 17'(vtx_data.pos_x));
                check_field("pos_y", 17'(want.pos_y), 17'(vtx_data.pos_y));
                check_field("tex_u", want.tex_u, vtx_data.tex_u);
                check_field("tex_v", want.tex_v, vtx_data.tex_v);
                check_field("last_vertex", 17'(want.last_vertex), 17'(vtx_data.last_vertex));
            end
            vertices_checked++;
        end
    end

    // Output side back-pressure, including one long hold that lets the block fill up.
    initial
    begin
        vtx_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_vertices)
            begin
                hold_vertices = 1'b0;
                vtx_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                vtx_ready <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                vtx_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                vtx_ready <= 1'b1;
            end
            else
            begin
                vtx_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_data    = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        rx_idle_on  = 1'b1;
        tx_idle_on  = 1'b1;
        hold_vertices = 1'b0;
        mismatches  = 0;
        vertices_checked = 0;
        n_loads     = 0;
        n_chars     = 0;
        n_newlines  = 0;
        n_settings  = 1;
        reg_origin_x        = 16'd0;
        reg_origin_y        = 16'd0;
        reg_line_height     = 8'd16;
        reg_tex_unit_x      = 16'd4096;
        reg_tex_unit_y      = 16'd8192;
        reg_max_glyph_width = 8'd16;
        pen_x = 16'd0;
        pen_y = 16'd0;
        for (int i = 0; i < GLYPHS; i++)
            glyph_loaded[i] = 1'b0;

        // Directed rows under the reset register values. Typed first vertices follow
        // directly from the pen position and the atlas cell of the code.
        dir_row(REQ_LOAD, 8'h41, 8'd8,   8'd9,   1'b0, 1'b0, '0, '0, '0, '0);
        dir_row(REQ_LOAD, 8'hFF, 8'd255, 8'd255, 1'b1, 1'b0, '0, '0, '0, '0);
        dir_row(REQ_LOAD, 8'h00, 8'd0,   8'd0,   1'b0, 1'b0, '0, '0, '0, '0);
        dir_row(REQ_LOAD, 8'h20, 8'd16,  8'd16,  1'b0, 1'b0, '0, '0, '0, '0);
        dir_row(REQ_CHAR, 8'h41, 8'd0,   8'd0,   1'b1, 1'b1, 16'd0, 16'd0, 17'd4096, 17'd32768);
        dir_row(REQ_CHAR, 8'h41, 8'd255, 8'd255, 1'b0, 1'b1, 16'd9, 16'd0, 17'd4096, 17'd32768);
        dir_row(REQ_CHAR, NEWLINE_CODE, 8'd0, 8'd0, 1'b0, 1'b0, '0, '0, '0, '0);
        // Bottom right cell: the lower v coordinate saturates.
        dir_row(REQ_CHAR, 8'hFF, 8'd0,   8'd0,   1'b0, 1'b1, 16'd0, 16'd16, 17'd61440,
                17'd122880);
        dir_row(REQ_CHAR, 8'h00, 8'd0,   8'd0,   1'b1, 1'b1, 16'd0, 16'd0, 17'd0, 17'd0);
        // A newline that starts a string: origin first, then one line down.
        dir_row(REQ_CHAR, NEWLINE_CODE, 8'd0, 8'd0, 1'b1, 1'b0, '0, '0, '0, '0);
        dir_row(REQ_CHAR, 8'h20, 8'd0,   8'd0,   1'b0, 1'b1, 16'd0, 16'd16, 17'd0, 17'd16384);
        dir_row(REQ_LOAD, 8'hFF, 8'd1,   8'd200, 1'b0, 1'b0, '0, '0, '0, '0);
        dir_row(REQ_CHAR, 8'hFF, 8'd0,   8'd0,   1'b0, 1'b1, 16'd16, 16'd16, 17'd61440,
                17'd122880);
        dir_row(REQ_LOAD, NEWLINE_CODE, 8'd77, 8'd77, 1'b0, 1'b0, '0, '0, '0, '0);
        dir_row(REQ_CHAR, NEWLINE_CODE, 8'd0, 8'd0, 1'b0, 1'b0, '0, '0, '0, '0);
        dir_row(REQ_CHAR, 8'h41, 8'd0,   8'd0,   1'b0, 1'b1, 16'd0, 16'd32, 17'd4096, 17'd32768);
        dir_row(REQ_LOAD, 8'h7E, 8'd170, 8'd85,  1'b0, 1'b0, '0, '0, '0, '0);
        dir_row(REQ_CHAR, 8'h7E, 8'd0,   8'd0,   1'b0, 1'b1, 16'd9, 16'd32, 17'd57344,
                17'd57344);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(negedge clk);

        foreach (directed_rows[i])
            drive_request(directed_rows[i].req, directed_rows[i].typed,
                          directed_rows[i].first_vtx);
        run_random(40, 1'b1, 1'b1, 1'b0, 1'b0);

        // Everything at its top value, with a long output stall while requests keep coming.
        apply_setting(16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF, 16'hFFFF, 8'd255);
        run_random(40, 1'b1, 1'b1, 1'b1, 1'b0);

        // Everything at zero, a zero divisor among it; the sender drains halfway through.
        apply_setting(16'd0, 16'd0, 8'd0, 16'd0, 16'd0, 8'd0);
        run_random(40, 1'b1, 1'b1, 1'b0, 1'b1);

        // Smallest divisor and widest column: the texture step saturates.
        apply_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 8'd16,
                      16'hFFFF, 16'd4096, 8'd1);
        run_random(40, 1'b1, 1'b0, 1'b0, 1'b0);

        apply_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        run_random(40, 1'b0, 1'b1, 1'b0, 1'b0);

        apply_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      8'($urandom_range(0, 64)), 16'($urandom_range(0, 8192)),
                      16'($urandom_range(0, 8192)), 8'($urandom_range(1, 32)));
        run_random(50, 1'b1, 1'b1, 1'b0, 1'b0);

        // Closing stretch at full rate on both sides.
        apply_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        run_random(50, 1'b0, 1'b0, 1'b0, 1'b0);

        $display("Covered %0d glyph loads, %0d characters and %0d newlines under %0d settings.",
                 n_loads, n_chars, n_newlines, n_settings);
        $display("Checked %0d vertices, %0d field mismatches.", vertices_checked, mismatches);
        if (mismatches == 0 && pending_vertices.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
